// ===== sv/kac_pkg.sv =====
// ----------------------------------------------------------------------------
// kac_pkg
// Shared types, codes and the remote command decoder for the keypad alarm
// controller.
// ----------------------------------------------------------------------------
package kac_pkg;

   localparam int KAC_CODE_DIGITS = 3;

   // Configuration port geometry.
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_PASS_CODE        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_THRESHOLD = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ALARM_TIMEOUT    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_RETRIES      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNLOCK_CARD      = 3'd4;

   localparam logic [11:0] PASS_CODE_RESET        = 12'h911;
   localparam logic [9:0]  MOTION_THRESHOLD_RESET = 10'd200;
   localparam logic [19:0] ALARM_TIMEOUT_RESET    = 20'd30000;
   localparam logic [3:0]  MAX_RETRIES_RESET      = 4'd2;
   localparam logic [7:0]  UNLOCK_CARD_RESET      = 8'd74;

   typedef struct packed {
      logic [11:0] pass_code;
      logic [9:0]  motion_threshold;
      logic [19:0] alarm_timeout;
      logic [3:0]  max_retries;
      logic [7:0]  unlock_card;
   } cfg_type;

   // Event kinds.
   localparam logic [1:0] FUNC_TICK   = 2'd0;
   localparam logic [1:0] FUNC_REMOTE = 2'd1;
   localparam logic [1:0] FUNC_SAMPLE = 2'd2;
   localparam logic [1:0] FUNC_CARD   = 2'd3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] ir_command;
      logic [9:0] pir_sample;
      logic [7:0] card_byte;
   } req_item_type;

   // Mode codes as reported on the result channel.
   localparam logic [2:0] MODE_CODE_OFF      = 3'd0;
   localparam logic [2:0] MODE_CODE_DISARMED = 3'd1;
   localparam logic [2:0] MODE_CODE_ARMED    = 3'd2;
   localparam logic [2:0] MODE_CODE_ALARM    = 3'd3;
   localparam logic [2:0] MODE_CODE_LOCKED   = 3'd4;

   typedef enum logic [4:0] {
      MODE_OFF      = 5'b00001,
      MODE_DISARMED = 5'b00010,
      MODE_ARMED    = 5'b00100,
      MODE_ALARM    = 5'b01000,
      MODE_LOCKED   = 5'b10000
   } mode_type;

   // Event result codes.
   localparam logic [3:0] EV_NONE     = 4'd0;
   localparam logic [3:0] EV_DIGIT    = 4'd1;
   localparam logic [3:0] EV_CLEARED  = 4'd2;
   localparam logic [3:0] EV_WRONG    = 4'd3;
   localparam logic [3:0] EV_ACCEPTED = 4'd4;
   localparam logic [3:0] EV_MOTION   = 4'd5;
   localparam logic [3:0] EV_TIMEOUT  = 4'd6;
   localparam logic [3:0] EV_LOCKOUT  = 4'd7;
   localparam logic [3:0] EV_UNLOCKED = 4'd8;

   typedef struct packed {
      logic [2:0]  mode;
      logic        green_led;
      logic        red_led;
      logic        lock_closed;
      logic        buzzer_on;
      logic [1:0]  digit_count;
      logic [11:0] shown_digits;
      logic [3:0]  event_res;
   } rsp_item_type;

   // Decoded keys: values below ten are digits.
   typedef logic [4:0] key_type;
   localparam key_type KEY_NONE = 5'd16;
   localparam key_type KEY_D    = 5'd17;
   localparam key_type KEY_C    = 5'd18;
   localparam key_type KEY_A    = 5'd19;

   function automatic key_type decode_cmd(input logic [7:0] cmd);
      key_type k;
      case (cmd)
         8'd69:   k = 5'd1;
         8'd70:   k = 5'd2;
         8'd71:   k = 5'd3;
         8'd68:   k = 5'd4;
         8'd64:   k = 5'd5;
         8'd67:   k = 5'd6;
         8'd7:    k = 5'd7;
         8'd21:   k = 5'd8;
         8'd9:    k = 5'd9;
         8'd25:   k = 5'd0;
         8'd22:   k = KEY_D;
         8'd13:   k = KEY_C;
         8'd28:   k = KEY_A;
         default: k = KEY_NONE;
      endcase
      return k;
   endfunction

endpackage

// ===== sv/kac_csr.sv =====
// ----------------------------------------------------------------------------
// kac_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module kac_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [kac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kac_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output kac_pkg::cfg_type                cfg
);
   import kac_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_PASS_CODE:        cfg_in.pass_code        = csr_wdata[11:0];
            CSR_MOTION_THRESHOLD: cfg_in.motion_threshold = csr_wdata[9:0];
            CSR_ALARM_TIMEOUT:    cfg_in.alarm_timeout    = csr_wdata[19:0];
            CSR_MAX_RETRIES:      cfg_in.max_retries      = csr_wdata[3:0];
            CSR_UNLOCK_CARD:      cfg_in.unlock_card      = csr_wdata[7:0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pass_code        <= PASS_CODE_RESET;
         cfg_ff.motion_threshold <= MOTION_THRESHOLD_RESET;
         cfg_ff.alarm_timeout    <= ALARM_TIMEOUT_RESET;
         cfg_ff.max_retries      <= MAX_RETRIES_RESET;
         cfg_ff.unlock_card      <= UNLOCK_CARD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/kac_in_stage.sv =====
// ----------------------------------------------------------------------------
// kac_in_stage
// Input register: holds one accepted item until the controller takes it.
// ----------------------------------------------------------------------------
module kac_in_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  kac_pkg::req_item_type req_item,
   output logic                  item_valid,
   output kac_pkg::req_item_type item,
   input  logic                  item_take
);
   import kac_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;

   // The register may refill in the same cycle in which its item is taken.
   assign req_ready = !valid_ff || item_take;
   assign valid_in  = (req_valid && req_ready) || (valid_ff && !item_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== sv/kac_fsm.sv =====
// ----------------------------------------------------------------------------
// kac_fsm
// Panel mode machine with code entry, motion check and alarm timer. It
// computes the result for the item in the input register and updates its
// state when that item is taken.
// ----------------------------------------------------------------------------
module kac_fsm #(
   parameter int CODE_DIGITS = kac_pkg::KAC_CODE_DIGITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  kac_pkg::cfg_type      cfg,
   input  kac_pkg::req_item_type item,
   input  logic                  item_take,
   output kac_pkg::rsp_item_type result
);
   import kac_pkg::*;

   localparam int DW = 4 * CODE_DIGITS;
   localparam int CW = $clog2(CODE_DIGITS + 1);

   mode_type        mode_ff,    mode_in;
   logic [DW-1:0]   digits_ff,  digits_in;
   logic [CW-1:0]   count_ff,   count_in;
   logic [9:0]      base_ff,    base_in;
   logic            base_ok_ff, base_ok_in;
   logic [3:0]      wrong_ff,   wrong_in;
   logic [19:0]     timer_ff,   timer_in;

   logic [3:0]      ev;
   key_type         key;
   logic [DW+11:0]  pass_ext;
   logic [DW-1:0]   pass_w;
   logic            code_ok;
   logic [CW-1:0]   pos;
   logic [DW-1:0]   digit_ext;
   logic [9:0]      sample_gap;
   logic [DW+11:0]  shown_ext;
   logic [CW+1:0]   count_ext;

   assign key        = decode_cmd(item.ir_command);
   assign pass_ext   = {{DW{1'b0}}, cfg.pass_code};
   assign pass_w     = pass_ext[DW-1:0];
   assign code_ok    = (count_ff == CW'(CODE_DIGITS)) && (digits_ff == pass_w);
   assign pos        = CW'(CODE_DIGITS - 1) - count_ff;
   assign digit_ext  = DW'(key[3:0]) << {pos, 2'b00};
   assign sample_gap = (item.pir_sample > base_ff) ? item.pir_sample - base_ff
                                                   : base_ff - item.pir_sample;

   always_comb begin
      mode_in    = mode_ff;
      digits_in  = digits_ff;
      count_in   = count_ff;
      base_in    = base_ff;
      base_ok_in = base_ok_ff;
      wrong_in   = wrong_ff;
      timer_in   = timer_ff;
      ev         = EV_NONE;
      case (item.func)
         FUNC_TICK: begin
            if (mode_ff == MODE_ALARM) begin
               // The timer saturates and is compared after it counts.
               if (timer_ff != {20{1'b1}}) begin
                  timer_in = timer_ff + 20'd1;
               end
               if (timer_in >= cfg.alarm_timeout) begin
                  mode_in = MODE_LOCKED;
                  ev      = EV_TIMEOUT;
               end
            end
         end
         FUNC_REMOTE: begin
            if (mode_ff == MODE_OFF) begin
               if (key == KEY_D) begin
                  mode_in   = MODE_DISARMED;
                  digits_in = '0;
                  count_in  = '0;
               end
            end else if (mode_ff == MODE_LOCKED || key == KEY_NONE) begin
               ev = EV_NONE;
            end else if (key == KEY_D) begin
               if (mode_ff == MODE_DISARMED) begin
                  mode_in   = MODE_OFF;
                  digits_in = '0;
                  count_in  = '0;
               end
            end else if (key == KEY_C) begin
               digits_in = '0;
               count_in  = '0;
               ev        = EV_CLEARED;
            end else if (key == KEY_A) begin
               digits_in = '0;
               count_in  = '0;
               if (code_ok) begin
                  ev = EV_ACCEPTED;
                  if (mode_ff == MODE_DISARMED) begin
                     mode_in    = MODE_ARMED;
                     base_ok_in = 1'b0;
                  end else begin
                     mode_in = MODE_DISARMED;
                  end
               end else if (mode_ff == MODE_ALARM) begin
                  if (wrong_ff < cfg.max_retries) begin
                     wrong_in = wrong_ff + 4'd1;
                     ev       = EV_WRONG;
                  end else begin
                     mode_in = MODE_LOCKED;
                     ev      = EV_LOCKOUT;
                  end
               end else begin
                  ev = EV_WRONG;
               end
            end else if (count_ff < CW'(CODE_DIGITS)) begin
               digits_in = digits_ff | digit_ext;
               count_in  = count_ff + CW'(1);
               ev        = EV_DIGIT;
            end
         end
         FUNC_SAMPLE: begin
            if (mode_ff == MODE_ARMED) begin
               if (!base_ok_ff) begin
                  base_in    = item.pir_sample;
                  base_ok_in = 1'b1;
               end else if (sample_gap > cfg.motion_threshold) begin
                  mode_in   = MODE_ALARM;
                  digits_in = '0;
                  count_in  = '0;
                  wrong_in  = '0;
                  timer_in  = '0;
                  ev        = EV_MOTION;
               end
            end
         end
         default: begin
            if (mode_ff == MODE_LOCKED && item.card_byte == cfg.unlock_card) begin
               mode_in    = MODE_OFF;
               digits_in  = '0;
               count_in   = '0;
               base_in    = '0;
               base_ok_in = 1'b0;
               wrong_in   = '0;
               timer_in   = '0;
               ev         = EV_UNLOCKED;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_OFF;
         digits_ff  <= '0;
         count_ff   <= '0;
         base_ff    <= '0;
         base_ok_ff <= 1'b0;
         wrong_ff   <= '0;
         timer_ff   <= '0;
      end else if (item_take) begin
         mode_ff    <= mode_in;
         digits_ff  <= digits_in;
         count_ff   <= count_in;
         base_ff    <= base_in;
         base_ok_ff <= base_ok_in;
         wrong_ff   <= wrong_in;
         timer_ff   <= timer_in;
      end
   end

   assign shown_ext = {12'b0, digits_in};
   assign count_ext = {2'b0, count_in};

   always_comb begin
      case (mode_in)
         MODE_OFF:      result.mode = MODE_CODE_OFF;
         MODE_DISARMED: result.mode = MODE_CODE_DISARMED;
         MODE_ARMED:    result.mode = MODE_CODE_ARMED;
         MODE_ALARM:    result.mode = MODE_CODE_ALARM;
         MODE_LOCKED:   result.mode = MODE_CODE_LOCKED;
         default:       result.mode = MODE_CODE_OFF;
      endcase
      result.green_led    = (mode_in == MODE_DISARMED);
      result.red_led      = (mode_in == MODE_ARMED) || (mode_in == MODE_ALARM) ||
                            (mode_in == MODE_LOCKED);
      result.lock_closed  = (mode_in == MODE_LOCKED);
      result.buzzer_on    = (mode_in == MODE_LOCKED);
      result.digit_count  = count_ext[1:0];
      result.shown_digits = shown_ext[11:0];
      result.event_res    = ev;
   end

endmodule

// ===== sv/keypad_alarm_controller_top.sv =====
// ----------------------------------------------------------------------------
// keypad_alarm_controller_top
// Alarm panel controller: one event item in, one status item out.
// ----------------------------------------------------------------------------
// An accepted item is held in the input register, and its result is then held
// in the result register; a low rsp_ready can stall either one.
// Throughput: one item per cycle while rsp_ready stays high; the mode update is
// a single pass of logic between the input register and the result register.
// Reset (synchronous, active high): mode off, code entry, baseline, retry
// count and alarm timer cleared; configuration registers return to their reset values.
module keypad_alarm_controller_top #(
   parameter int CODE_DIGITS = kac_pkg::KAC_CODE_DIGITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_en,
   input  logic [kac_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kac_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_func,
   input  logic [7:0]                      req_ir_command,
   input  logic [9:0]                      req_pir_sample,
   input  logic [7:0]                      req_card_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_mode,
   output logic                            rsp_green_led,
   output logic                            rsp_red_led,
   output logic                            rsp_lock_closed,
   output logic                            rsp_buzzer_on,
   output logic [1:0]                      rsp_digit_count,
   output logic [11:0]                     rsp_shown_digits,
   output logic [3:0]                      rsp_event_res
);
   import kac_pkg::*;

   cfg_type      cfg;
   req_item_type req_item;
   req_item_type item;
   logic         item_valid;
   logic         item_take;
   rsp_item_type result;
   rsp_item_type rsp_ff;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;

   assign req_item.func       = req_func;
   assign req_item.ir_command = req_ir_command;
   assign req_item.pir_sample = req_pir_sample;
   assign req_item.card_byte  = req_card_byte;

   kac_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   kac_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   kac_fsm #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_fsm (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .item      (item),
      .item_take (item_take),
      .result    (result)
   );

   // An item moves on whenever the result register is empty or being emptied.
   assign item_take    = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = item_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_mode         = rsp_ff.mode;
   assign rsp_green_led    = rsp_ff.green_led;
   assign rsp_red_led      = rsp_ff.red_led;
   assign rsp_lock_closed  = rsp_ff.lock_closed;
   assign rsp_buzzer_on    = rsp_ff.buzzer_on;
   assign rsp_digit_count  = rsp_ff.digit_count;
   assign rsp_shown_digits = rsp_ff.shown_digits;
   assign rsp_event_res    = rsp_ff.event_res;

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_leds_follow_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_green_led == (rsp_mode == MODE_CODE_DISARMED)) &&
                    (rsp_lock_closed == (rsp_mode == MODE_CODE_LOCKED)) &&
                    (rsp_buzzer_on == rsp_lock_closed))
      else $error("indicator outputs disagree with mode");

   a_unlock_to_off: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_UNLOCKED) |->
         (rsp_mode == MODE_CODE_OFF) && (rsp_digit_count == 2'd0))
      else $error("unlock did not return the panel to off");

   a_motion_to_alarm: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_MOTION) |->
         (rsp_mode == MODE_CODE_ALARM) && (rsp_shown_digits == 12'd0))
      else $error("motion event without a clean alarm entry");

endmodule
